@@ design/cbe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbe_pkg: shared types and constants of the base-70 coordinate encoder
// Job record, lane status, state codes, reciprocal constants, symbol table.
// ----------------------------------------------------------------------------
package cbe_pkg;

  localparam int unsigned MAG_W     = 32;
  localparam int unsigned CHAR_W    = 7;
  localparam int unsigned QUOT_W    = 26;  // floor((2^32-1)/70) < 2^26
  localparam int unsigned RADIX     = 70;

  // floor(v/70) = floor(floor(v/2)/35) = (floor(v/2) * RECIP_35) >> RECIP_SHIFT,
  // exact for every 31-bit floor(v/2)
  localparam logic [31:0] RECIP_35    = 32'd3926827243;
  localparam int unsigned RECIP_SHIFT = 37;

  localparam logic [CHAR_W-1:0] QUAD_W = 7'h57;  // 'W'
  localparam logic [CHAR_W-1:0] QUAD_A = 7'h41;  // 'A'
  localparam logic [CHAR_W-1:0] QUAD_D = 7'h44;  // 'D'
  localparam logic [CHAR_W-1:0] QUAD_S = 7'h53;  // 'S'

  localparam logic [0:RADIX-1][7:0] ALPHABET =
    "1234567890poiuytrewqlkjhgfdsamnbvcxzPOIUYTREWQLKJHGFDSAMNBVCXZ@#%$&=-_";

  typedef struct packed {
    logic [CHAR_W-1:0] quad;
    logic [MAG_W-1:0]  x_mag;
    logic [MAG_W-1:0]  y_mag;
  } job_t;

  typedef struct packed {
    logic idle;
    logic done;
  } lane_stat_t;

  typedef enum logic [3:0] {
    LN_IDLE = 4'b0001,
    LN_MUL  = 4'b0010,
    LN_SUB  = 4'b0100,
    LN_DONE = 4'b1000
  } lane_state_t;

  typedef enum logic [2:0] {
    PH_QUAD = 3'b001,
    PH_X    = 3'b010,
    PH_Y    = 3'b100
  } emit_phase_t;

  function automatic logic [CHAR_W-1:0] digit_symbol(input logic [6:0] d);
    logic [CHAR_W-1:0] s;
    s = '0;
    if (d < 7'(RADIX)) begin
      s = ALPHABET[d][CHAR_W-1:0];
    end
    return s;
  endfunction

endpackage

@@ design/coord_base70_encoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coord_base70_encoder: coordinate pair to base-70 text code
// Quadrant letter, then base-70 digits of |x| and |y| through a fixed
// 70-symbol alphabet, one character beat per cycle while the sink is ready, last one flagged.
// ----------------------------------------------------------------------------
//
//  channel | ports                                  | direction
//  --------+----------------------------------------+----------
//  input   | in_valid, in_ready, in_x_micro, in_y_micro | in
//  result  | out_valid, out_ready, out_code_char,   | out
//          | out_last_char                          |
//
// Beats: a pair of dx and dy digits gives 1 + dx + dy beats (3 to 13 at
// six digits). Both magnitudes convert in parallel lanes, each digit a
// reciprocal multiply step, then a remainder step; the lanes take the next
// pair after the hand-off, while the streamer sends the previous code.
// Reset (rst_n low, synchronous) empties the input queue and idles lanes and
// streamer; no clearing pass. A stalled sink holds the output register; the
// lanes and a two-entry input queue keep taking work until they fill.
// ----------------------------------------------------------------------------
module coord_base70_encoder import cbe_pkg::*; #(
  parameter int MAX_DIGITS = 6
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_x_micro,
  input  logic signed [31:0] in_y_micro,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [6:0]         out_code_char,
  output logic               out_last_char
);

  localparam int CW = $clog2(MAX_DIGITS + 1);

  logic              job_valid, job_ready;
  job_t              job;
  lane_stat_t        x_stat, y_stat;
  logic [CW-1:0]     x_cnt, y_cnt;
  logic [CHAR_W-1:0] x_dig [MAX_DIGITS];
  logic [CHAR_W-1:0] y_dig [MAX_DIGITS];
  logic [CHAR_W-1:0] quad_r;
  logic              emit_busy;
  logic              load;

  cbe_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_x_micro (in_x_micro),
    .in_y_micro (in_y_micro),
    .job_valid  (job_valid),
    .job_ready  (job_ready),
    .job        (job)
  );

  // a job leaves the queue only when both lanes are free
  assign job_ready = x_stat.idle && y_stat.idle;

  // hand off to the streamer once both lanes finish and it is free
  assign load = x_stat.done && y_stat.done && !emit_busy;

  always_ff @(posedge clk) begin
    if (job_valid && job_ready) begin
      quad_r <= job.quad;
    end
  end

  cbe_lane #(.MAX_DIGITS(MAX_DIGITS)) u_lane_x (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (job_valid && job_ready),
    .clear  (load),
    .mag    (job.x_mag),
    .stat   (x_stat),
    .count  (x_cnt),
    .digits (x_dig)
  );

  cbe_lane #(.MAX_DIGITS(MAX_DIGITS)) u_lane_y (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (job_valid && job_ready),
    .clear  (load),
    .mag    (job.y_mag),
    .stat   (y_stat),
    .count  (y_cnt),
    .digits (y_dig)
  );

  cbe_emit #(.MAX_DIGITS(MAX_DIGITS)) u_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (load),
    .quad          (quad_r),
    .x_count       (x_cnt),
    .x_digits      (x_dig),
    .y_count       (y_cnt),
    .y_digits      (y_dig),
    .busy          (emit_busy),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_code_char (out_code_char),
    .out_last_char (out_last_char)
  );

endmodule

@@ design/cbe_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbe_front: input stage
// Takes coordinate beats, derives quadrant letter and magnitudes, and holds
// them in a two-entry queue for the conversion side.
// ----------------------------------------------------------------------------
module cbe_front import cbe_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic signed [31:0] in_x_micro,
  input  logic signed [31:0] in_y_micro,
  output logic              job_valid,
  input  logic              job_ready,
  output job_t              job
);

  job_t        q_r [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  cnt_r;
  logic        push, pop;
  logic        x_neg, y_neg, x_pos, y_pos;
  job_t        fresh;

  assign x_neg = in_x_micro[31];
  assign y_neg = in_y_micro[31];
  assign x_pos = !x_neg && (in_x_micro != '0);
  assign y_pos = !y_neg && (in_y_micro != '0);

  always_comb begin
    priority if (x_pos && y_pos) fresh.quad = QUAD_W;
    else if (x_neg && y_pos)     fresh.quad = QUAD_A;
    else if (x_pos && y_neg)     fresh.quad = QUAD_D;
    else                         fresh.quad = QUAD_S;
    // -2^31 negates to 0x80000000, which is its magnitude read unsigned
    fresh.x_mag = x_neg ? MAG_W'(-in_x_micro) : MAG_W'(in_x_micro);
    fresh.y_mag = y_neg ? MAG_W'(-in_y_micro) : MAG_W'(in_y_micro);
  end

  assign in_ready  = (cnt_r != 2'd2);
  assign job_valid = (cnt_r != 2'd0);
  assign job       = q_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = job_valid && job_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      cnt_r <= 2'(cnt_r + {1'b0, push} - {1'b0, pop});
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= fresh;
    end
  end

endmodule

@@ design/cbe_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbe_lane: magnitude to base-70 digit symbols
// Each digit is a reciprocal multiply step, then a remainder and update step.
// Digits are stored least significant first.
// ----------------------------------------------------------------------------
module cbe_lane import cbe_pkg::*; #(
  parameter int MAX_DIGITS = 6,
  parameter int CW = $clog2(MAX_DIGITS + 1),
  parameter int IW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              clear,
  input  logic [MAG_W-1:0]  mag,
  output lane_stat_t        stat,
  output logic [CW-1:0]     count,
  output logic [CHAR_W-1:0] digits [MAX_DIGITS]
);

  lane_state_t       state_r, state_nxt;
  logic [MAG_W-1:0]  val_r;
  logic [QUOT_W-1:0] q_r;
  logic [CW-1:0]     cnt_r;
  logic [CHAR_W-1:0] dig_r [MAX_DIGITS];
  logic [62:0]       prod;
  logic [MAG_W-1:0]  q70;
  logic [6:0]        rem;

  assign prod = 63'(val_r[MAG_W-1:1]) * 63'(RECIP_35);
  assign q70  = (MAG_W'(q_r) << 6) + (MAG_W'(q_r) << 2) + (MAG_W'(q_r) << 1);
  assign rem  = 7'(val_r - q70);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      LN_IDLE: if (start) state_nxt = LN_MUL;
      LN_MUL:  state_nxt = LN_SUB;
      LN_SUB: begin
        if ((q_r == '0) || (cnt_r == CW'(MAX_DIGITS - 1))) state_nxt = LN_DONE;
        else state_nxt = LN_MUL;
      end
      LN_DONE: if (clear) state_nxt = LN_IDLE;
      default: state_nxt = LN_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= LN_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == LN_IDLE) && start) begin
      val_r <= mag;
      cnt_r <= '0;
    end
    if (state_r == LN_MUL) begin
      q_r <= prod[RECIP_SHIFT +: QUOT_W];
    end
    if (state_r == LN_SUB) begin
      dig_r[cnt_r[IW-1:0]] <= digit_symbol(rem);
      cnt_r <= CW'(cnt_r + 1'b1);
      val_r <= MAG_W'(q_r);
    end
  end

  assign stat.idle = (state_r == LN_IDLE);
  assign stat.done = (state_r == LN_DONE);
  assign count     = cnt_r;
  assign digits    = dig_r;

endmodule

@@ design/cbe_emit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbe_emit: character streamer
// Holds one finished code and sends quadrant letter, x digits, y digits,
// most significant first, one beat per cycle while the sink is ready, through an output register.
// ----------------------------------------------------------------------------
module cbe_emit import cbe_pkg::*; #(
  parameter int MAX_DIGITS = 6,
  parameter int CW = $clog2(MAX_DIGITS + 1),
  parameter int IW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  logic [CHAR_W-1:0] quad,
  input  logic [CW-1:0]     x_count,
  input  logic [CHAR_W-1:0] x_digits [MAX_DIGITS],
  input  logic [CW-1:0]     y_count,
  input  logic [CHAR_W-1:0] y_digits [MAX_DIGITS],
  output logic              busy,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAR_W-1:0] out_code_char,
  output logic              out_last_char
);

  logic              active_r;
  emit_phase_t       phase_r;
  logic [IW-1:0]     idx_r;
  logic [CHAR_W-1:0] quad_r;
  logic [CW-1:0]     yc_r;
  logic [CHAR_W-1:0] xd_r [MAX_DIGITS];
  logic [CHAR_W-1:0] yd_r [MAX_DIGITS];
  logic              out_valid_r, last_r;
  logic [CHAR_W-1:0] code_r;
  logic              step;

  assign step = active_r && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      phase_r     <= PH_QUAD;
      out_valid_r <= 1'b0;
    end else begin
      if (load && !active_r) begin
        active_r <= 1'b1;
        phase_r  <= PH_QUAD;
      end
      if (step) begin
        out_valid_r <= 1'b1;
        unique case (phase_r)
          PH_QUAD: phase_r <= PH_X;
          PH_X:    if (idx_r == '0) phase_r <= PH_Y;
          PH_Y:    if (idx_r == '0) active_r <= 1'b0;
          default: phase_r <= PH_QUAD;
        endcase
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !active_r) begin
      quad_r <= quad;
      yc_r   <= y_count;
      xd_r   <= x_digits;
      yd_r   <= y_digits;
      idx_r  <= IW'(x_count - 1'b1);
    end
    if (step) begin
      unique case (phase_r)
        PH_QUAD: begin
          code_r <= quad_r;
          last_r <= 1'b0;
        end
        PH_X: begin
          code_r <= xd_r[idx_r];
          last_r <= 1'b0;
          idx_r  <= (idx_r == '0) ? IW'(yc_r - 1'b1) : IW'(idx_r - 1'b1);
        end
        PH_Y: begin
          code_r <= yd_r[idx_r];
          last_r <= (idx_r == '0);
          idx_r  <= IW'(idx_r - 1'b1);
        end
        default: last_r <= 1'b0;
      endcase
    end
  end

  assign busy          = active_r;
  assign out_valid     = out_valid_r;
  assign out_code_char = code_r;
  assign out_last_char = last_r;

endmodule

@@ test/coord_base70_encoder_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coord_base70_encoder_test: self-checking bench for the base-70 coord encoder
// Drives coordinate pairs over valid/ready, predicts each character beat
// (quadrant letter, then base-70 digits of |x| and |y|), and checks every
// beat in order under several sender and sink idling mixes, plus one long
// sink hold-off that backs up the input.
// ----------------------------------------------------------------------------
module coord_base70_encoder_test;
  import cbe_pkg::*;

  localparam int NUM_DIGITS   = 6;     // digit slots per magnitude in the dut
  localparam int BASE         = 70;
  localparam int MAX_BEATS    = 1 + 2 * NUM_DIGITS;
  localparam int WDOG_LIMIT   = 3000;  // cycles with no beat on either side
  localparam int DRAIN_CYCLES = 60;    // settle time after the last beat
  localparam int HOLD_CYCLES  = 400;   // long sink hold-off
  localparam int MAX_PRINTS   = 40;

  // Digit symbol table, index 0 is the leftmost character.
  localparam logic [8*BASE-1:0] SYMBOLS =
    "1234567890poiuytrewqlkjhgfdsamnbvcxzPOIUYTREWQLKJHGFDSAMNBVCXZ@#%$&=-_";

  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } code_beat_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [31:0] in_x_micro;
  logic signed [31:0] in_y_micro;
  logic               out_valid;
  logic               out_ready;
  logic [6:0]         out_code_char;
  logic               out_last_char;

  code_beat_t code_q[$];  // characters still owed by the dut, oldest first

  int errors;
  int pairs_sent;
  int beats_checked;
  int send_idle_pct;
  int sink_stall_pct;
  int hold_req_seq;
  int hold_ack_seq;
  int hold_left;
  int idle_run;

  coord_base70_encoder dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_x_micro    (in_x_micro),
    .in_y_micro    (in_y_micro),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_code_char (out_code_char),
    .out_last_char (out_last_char)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // --------------------------------------------------------------------------
  // Predictor: the full character string for one pair, in emit order.
  // Magnitudes are taken on 33 bits so that -2^31 keeps its true size 2^31.
  // --------------------------------------------------------------------------
  function automatic void predict_code(input logic [31:0] x, input logic [31:0] y);
    logic [32:0] mag;
    logic [6:0]  rev [NUM_DIGITS];
    logic [6:0]  beats [MAX_BEATS];
    logic        x_pos, y_pos, x_neg, y_neg;
    code_beat_t  b;
    int          n, k, d;

    x_neg = x[31];
    y_neg = y[31];
    x_pos = !x_neg && (x != 32'd0);
    y_pos = !y_neg && (y != 32'd0);

    // any zero coordinate, or both negative, falls through to S
    if (x_pos && y_pos)      beats[0] = QUAD_W;
    else if (x_neg && y_pos) beats[0] = QUAD_A;
    else if (x_pos && y_neg) beats[0] = QUAD_D;
    else                     beats[0] = QUAD_S;
    k = 1;

    for (int c = 0; c < 2; c++) begin
      mag = (c == 0) ? {1'b0, x} : {1'b0, y};
      if (mag[31]) mag = 33'h1_0000_0000 - mag;
      // zero still gives one digit; only the low NUM_DIGITS digits survive
      n = 0;
      do begin
        d = int'(mag % 33'(BASE));
        rev[n] = SYMBOLS[8*(BASE-1-d) +: 7];
        mag = mag / 33'(BASE);
        n++;
      end while (mag != 33'd0 && n < NUM_DIGITS);
      for (int i = n - 1; i >= 0; i--) begin
        beats[k] = rev[i];
        k++;
      end
    end

    for (int i = 0; i < k; i++) begin
      b.ch   = beats[i];
      b.last = (i == k - 1);
      code_q.push_back(b);
    end
  endfunction

  task automatic report(input string what);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // --------------------------------------------------------------------------
  // Sender: one pair per call. Entered and left at a falling edge, so valid
  // stays high across back-to-back pairs without a low blip.
  // --------------------------------------------------------------------------
  task automatic send_pair(input logic [31:0] x, input logic [31:0] y);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    in_x_micro = x;
    in_y_micro = y;
    do @(posedge clk); while (!in_ready);
    predict_code(x, y);
    pairs_sent++;
    @(negedge clk);
  endtask

  // Random coordinate weighted toward short magnitudes and the range edges,
  // with enough full-width values that every input bit toggles.
  function automatic logic [31:0] rand_coord();
    logic [31:0] v;
    case ($urandom_range(7))
      0: v = 32'd0;
      1: v = 32'($urandom_range(BASE - 1));
      2: begin
        case ($urandom_range(4))
          0: v = 32'h7fff_ffff;
          1: v = 32'h8000_0000;
          2: v = 32'h8000_0001;
          3: v = 32'd1;
          default: v = 32'hffff_ffff;
        endcase
      end
      3: v = $urandom;
      default: v = $urandom >> $urandom_range(31);
    endcase
    if ($urandom_range(1) == 1) v = -v;
    return v;
  endfunction

  task automatic send_random_pairs(input int count);
    for (int i = 0; i < count; i++) send_pair(rand_coord(), rand_coord());
  endtask

  // --------------------------------------------------------------------------
  // Sink: ready driven at the falling edge. A hold-off request from a test
  // forces ready low for HOLD_CYCLES, counted here.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_req_seq != hold_ack_seq) begin
      hold_ack_seq = hold_req_seq;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else begin
      out_ready = ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Result checker: every accepted beat against the oldest owed character.
  always @(posedge clk) begin
    code_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      beats_checked++;
      if (code_q.size() == 0) begin
        report($sformatf("unexpected beat char=%02h last=%0b",
                         out_code_char, out_last_char));
      end else begin
        want = code_q.pop_front();
        if (out_code_char !== want.ch)
          report($sformatf("code_char got %02h want %02h", out_code_char, want.ch));
        if (out_last_char !== want.last)
          report($sformatf("last_char got %0b want %0b", out_last_char, want.last));
      end
    end
  end

  // Watchdog: a run of cycles with no beat on either channel means a hang.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      idle_run = 0;
    else
      idle_run++;
    if (idle_run >= WDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d chars still owed",
               idle_run, code_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Range edges, each quadrant, zeros, digit-count boundaries, -2^31.
  task automatic test_directed();
    send_idle_pct  = 0;
    sink_stall_pct = 0;
    send_pair(32'd0, 32'd0);
    send_pair(32'd1, 32'd1);
    send_pair(-32'sd1, 32'd1);
    send_pair(32'd1, -32'sd1);
    send_pair(-32'sd1, -32'sd1);
    send_pair(32'd0, 32'd5);
    send_pair(32'd5, 32'd0);
    send_pair(32'd0, -32'sd5);
    send_pair(-32'sd5, 32'd0);
    send_pair(32'd69, -32'sd69);
    send_pair(32'd70, -32'sd70);
    send_pair(32'd4899, 32'd4900);
    send_pair(32'd1680699999, -32'sd1680700000);
    send_pair(32'h7fff_ffff, 32'h7fff_ffff);
    send_pair(32'h8000_0001, 32'h8000_0001);
    send_pair(32'h8000_0000, 32'h7fff_ffff);
    send_pair(32'h7fff_ffff, 32'h8000_0000);
    send_pair(32'h8000_0000, 32'h8000_0000);
    send_pair(32'h5555_5555, 32'haaaa_aaaa);
    send_pair(32'haaaa_aaaa, 32'h5555_5555);
    send_pair(32'd12345678, -32'sd98765432);
    send_pair(-32'sd45000000, 32'd120000000);
  endtask

  task automatic test_streaming();
    send_idle_pct  = 0;
    sink_stall_pct = 0;
    send_random_pairs(80);
  endtask

  task automatic test_sender_gaps();
    send_idle_pct  = 68;
    sink_stall_pct = 0;
    send_random_pairs(65);
  endtask

  task automatic test_sink_stalls();
    send_idle_pct  = 0;
    sink_stall_pct = 68;
    send_random_pairs(65);
  endtask

  task automatic test_both_idle();
    send_idle_pct  = 8;
    sink_stall_pct = 8;
    send_random_pairs(60);
  endtask

  // Sink holds off for a long stretch while pairs keep coming; the input
  // queue and lanes fill and in_ready must drop without losing a pair.
  task automatic test_input_backup();
    send_idle_pct  = 0;
    sink_stall_pct = 0;
    hold_req_seq++;
    send_random_pairs(25);
  endtask

  initial begin
    errors        = 0;
    pairs_sent    = 0;
    beats_checked = 0;
    send_idle_pct = 0;
    sink_stall_pct = 0;
    hold_req_seq  = 0;
    hold_ack_seq  = 0;
    hold_left     = 0;
    idle_run      = 0;
    in_valid      = 1'b0;
    in_x_micro    = '0;
    in_y_micro    = '0;
    out_ready     = 1'b0;
    rst_n         = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_streaming();
    test_sender_gaps();
    test_sink_stalls();
    test_both_idle();
    test_input_backup();
    in_valid = 1'b0;

    // Let every owed character arrive, then watch for strays.
    while (code_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d pairs (edges, all quadrants, 1..6 digit magnitudes), %0d beats",
             pairs_sent, beats_checked);
    $display("idling mixes: none, sender gaps, sink stalls, both, long sink hold-off");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
